### design/whp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whp_pkg
// shared types and constants of the wav header parser
// ----------------------------------------------------------------------------
package whp_pkg;

    localparam int DATA_W   = 8;
    localparam int WORD_W   = 32;
    localparam int HALF_W   = 16;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;

    localparam int DIV_STEPS = WORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [WORD_W-1:0] TAG_RIFF      = 32'h4646_4952;
    localparam logic [WORD_W-1:0] TAG_WAVE      = 32'h4556_4157;
    localparam logic [WORD_W-1:0] TAG_FMT       = 32'h2074_6D66;
    localparam logic [WORD_W-1:0] TAG_DATA      = 32'h6174_6164;
    localparam logic [WORD_W-1:0] FMT_CHUNK_LEN = 32'd16;

    localparam logic [POS_W-1:0] POS_RIFF     = 6'd3;
    localparam logic [POS_W-1:0] POS_SIZE     = 6'd7;
    localparam logic [POS_W-1:0] POS_WAVE     = 6'd11;
    localparam logic [POS_W-1:0] POS_FMT      = 6'd15;
    localparam logic [POS_W-1:0] POS_FMT_LEN  = 6'd19;
    localparam logic [POS_W-1:0] POS_FORMAT   = 6'd21;
    localparam logic [POS_W-1:0] POS_CHANNELS = 6'd23;
    localparam logic [POS_W-1:0] POS_RATE     = 6'd27;
    localparam logic [POS_W-1:0] POS_BYTERATE = 6'd31;
    localparam logic [POS_W-1:0] POS_BITS     = 6'd35;
    localparam logic [POS_W-1:0] POS_DATA     = 6'd39;
    localparam logic [POS_W-1:0] POS_LAST     = 6'd43;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_RIFF = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_WAVE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_FMT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_PCM  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_DATA = 3'd6;

    typedef struct packed {
        logic accept;
        logic div_step;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic emit_ok;
    } stat_t;

endpackage

`default_nettype wire

### design/whp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whp_if
// byte stream and result channels of the wav header parser
// ----------------------------------------------------------------------------
interface whp_byte_if;
    logic                       valid;
    logic                       ready;
    logic [whp_pkg::DATA_W-1:0] data_byte;
    logic                       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface whp_result_if;
    logic                         valid;
    logic                         ready;
    logic [whp_pkg::STATUS_W-1:0] status;
    logic [whp_pkg::WORD_W-1:0]   chunk_size;
    logic [whp_pkg::HALF_W-1:0]   audio_format;
    logic [whp_pkg::HALF_W-1:0]   num_channels;
    logic [whp_pkg::WORD_W-1:0]   sample_rate;
    logic [whp_pkg::WORD_W-1:0]   byte_rate;
    logic [whp_pkg::HALF_W-1:0]   bits_per_sample;
    logic [whp_pkg::WORD_W-1:0]   data_size;
    logic [whp_pkg::WORD_W-1:0]   duration_seconds;

    modport source (output valid, output status, output chunk_size, output audio_format,
        output num_channels, output sample_rate, output byte_rate, output bits_per_sample,
        output data_size, output duration_seconds, input ready);
    modport sink (input valid, input status, input chunk_size, input audio_format,
        input num_channels, input sample_rate, input byte_rate, input bits_per_sample,
        input data_size, input duration_seconds, output ready);
endinterface

`default_nettype wire

### design/whp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whp_datapath
// byte gathering, header checks, field registers and serial divider
// ----------------------------------------------------------------------------
module whp_datapath (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire whp_pkg::cmd_t           cmd,
    input  wire [whp_pkg::DATA_W-1:0]    data_byte,
    input  wire                          last_byte,
    output whp_pkg::stat_t               stat,
    output logic [whp_pkg::STATUS_W-1:0] status,
    output logic [whp_pkg::WORD_W-1:0]   chunk_size,
    output logic [whp_pkg::HALF_W-1:0]   audio_format,
    output logic [whp_pkg::HALF_W-1:0]   num_channels,
    output logic [whp_pkg::WORD_W-1:0]   sample_rate,
    output logic [whp_pkg::WORD_W-1:0]   byte_rate,
    output logic [whp_pkg::HALF_W-1:0]   bits_per_sample,
    output logic [whp_pkg::WORD_W-1:0]   data_size,
    output logic [whp_pkg::WORD_W-1:0]   duration_seconds
);

    logic [whp_pkg::POS_W-1:0]  pos_reg;
    logic                       skip_reg;
    logic [whp_pkg::WORD_W-1:0] gather_reg;
    logic [whp_pkg::WORD_W-1:0] riff_size_reg;
    logic [whp_pkg::HALF_W-1:0] format_code_reg;
    logic [whp_pkg::HALF_W-1:0] channels_reg;
    logic [whp_pkg::WORD_W-1:0] rate_reg;
    logic [whp_pkg::WORD_W-1:0] byterate_reg;
    logic [whp_pkg::HALF_W-1:0] sample_bits_reg;

    logic [whp_pkg::STATUS_W-1:0] status_reg;
    logic [whp_pkg::WORD_W-1:0]   chunk_size_reg;
    logic [whp_pkg::HALF_W-1:0]   audio_format_reg;
    logic [whp_pkg::HALF_W-1:0]   num_channels_reg;
    logic [whp_pkg::WORD_W-1:0]   sample_rate_reg;
    logic [whp_pkg::WORD_W-1:0]   byte_rate_reg;
    logic [whp_pkg::HALF_W-1:0]   bits_per_sample_reg;
    logic [whp_pkg::WORD_W-1:0]   data_size_reg;

    logic [whp_pkg::WORD_W-1:0] divisor_reg;
    logic [whp_pkg::WORD_W-1:0] quo_reg;
    logic [whp_pkg::WORD_W-1:0] rem_reg;

    logic [whp_pkg::WORD_W-1:0]   gather_next;
    logic                         chk_fail;
    logic [whp_pkg::STATUS_W-1:0] chk_code;
    logic                         at_end;
    logic                         emit;
    logic                         emit_ok;
    logic [whp_pkg::WORD_W-1:0]   payload_next;
    logic [whp_pkg::WORD_W:0]     rem_shift;
    logic [whp_pkg::WORD_W:0]     rem_diff;

    assign gather_next = {data_byte, gather_reg[whp_pkg::WORD_W-1:whp_pkg::DATA_W]};

    always_comb
    begin
        chk_fail = 1'b0;
        chk_code = whp_pkg::ST_OK;
        case (pos_reg)
            whp_pkg::POS_RIFF:
            begin
                chk_fail = gather_next != whp_pkg::TAG_RIFF;
                chk_code = whp_pkg::ST_NOT_RIFF;
            end
            whp_pkg::POS_WAVE:
            begin
                chk_fail = gather_next != whp_pkg::TAG_WAVE;
                chk_code = whp_pkg::ST_NOT_WAVE;
            end
            whp_pkg::POS_FMT:
            begin
                chk_fail = gather_next != whp_pkg::TAG_FMT;
                chk_code = whp_pkg::ST_BAD_FMT;
            end
            whp_pkg::POS_FMT_LEN:
            begin
                chk_fail = gather_next != whp_pkg::FMT_CHUNK_LEN;
                chk_code = whp_pkg::ST_NOT_PCM;
            end
            whp_pkg::POS_DATA:
            begin
                chk_fail = gather_next != whp_pkg::TAG_DATA;
                chk_code = whp_pkg::ST_BAD_DATA;
            end
            default:
            begin
                chk_fail = 1'b0;
                chk_code = whp_pkg::ST_OK;
            end
        endcase
    end

    assign at_end       = pos_reg >= whp_pkg::POS_LAST;
    assign emit         = !skip_reg && (chk_fail || at_end || last_byte);
    assign emit_ok      = !chk_fail && at_end;
    assign payload_next = gather_next;

    assign stat.emit    = emit;
    assign stat.emit_ok = emit_ok;

    // restoring division, one quotient bit per step
    assign rem_shift = {rem_reg, quo_reg[whp_pkg::WORD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            skip_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (skip_reg)
            begin
                if (last_byte)
                begin
                    pos_reg  <= '0;
                    skip_reg <= 1'b0;
                end
            end
            else if (emit)
            begin
                pos_reg  <= '0;
                skip_reg <= !last_byte;
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && !skip_reg)
        begin
            gather_reg <= gather_next;
            case (pos_reg)
                whp_pkg::POS_SIZE:     riff_size_reg   <= gather_next;
                whp_pkg::POS_FORMAT:
                    format_code_reg <= gather_next[whp_pkg::WORD_W-1:whp_pkg::HALF_W];
                whp_pkg::POS_CHANNELS:
                    channels_reg    <= gather_next[whp_pkg::WORD_W-1:whp_pkg::HALF_W];
                whp_pkg::POS_RATE:     rate_reg        <= gather_next;
                whp_pkg::POS_BYTERATE: byterate_reg    <= gather_next;
                whp_pkg::POS_BITS:
                    sample_bits_reg <= gather_next[whp_pkg::WORD_W-1:whp_pkg::HALF_W];
                default:               ;
            endcase
            if (emit)
            begin
                status_reg <= emit_ok ? whp_pkg::ST_OK : (chk_fail ? chk_code : whp_pkg::ST_SHORT);
                chunk_size_reg      <= emit_ok ? riff_size_reg   : '0;
                audio_format_reg    <= emit_ok ? format_code_reg : '0;
                num_channels_reg    <= emit_ok ? channels_reg    : '0;
                sample_rate_reg     <= emit_ok ? rate_reg        : '0;
                byte_rate_reg       <= emit_ok ? byterate_reg    : '0;
                bits_per_sample_reg <= emit_ok ? sample_bits_reg : '0;
                data_size_reg       <= emit_ok ? payload_next    : '0;
                divisor_reg         <= emit_ok ? byterate_reg    : '0;
                quo_reg             <= payload_next;
                rem_reg             <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            if (!rem_diff[whp_pkg::WORD_W])
            begin
                rem_reg <= rem_diff[whp_pkg::WORD_W-1:0];
                quo_reg <= {quo_reg[whp_pkg::WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[whp_pkg::WORD_W-1:0];
                quo_reg <= {quo_reg[whp_pkg::WORD_W-2:0], 1'b0};
            end
        end
    end

    assign status           = status_reg;
    assign chunk_size       = chunk_size_reg;
    assign audio_format     = audio_format_reg;
    assign num_channels     = num_channels_reg;
    assign sample_rate      = sample_rate_reg;
    assign byte_rate        = byte_rate_reg;
    assign bits_per_sample  = bits_per_sample_reg;
    assign data_size        = data_size_reg;
    // zero divisor covers both a zero byte rate and error results
    assign duration_seconds = (divisor_reg == '0) ? '0 : quo_reg;

endmodule

`default_nettype wire

### design/whp_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whp_controller
// handshake control and division sequencing of the wav header parser
// ----------------------------------------------------------------------------
module whp_controller (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire                 out_ready,
    input  wire whp_pkg::stat_t stat,
    output whp_pkg::cmd_t       cmd
);

    localparam logic S_RUN = 1'b0;
    localparam logic S_DIV = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    logic [whp_pkg::CNT_W-1:0] cnt_reg;
    logic [whp_pkg::CNT_W-1:0] cnt_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      div_last;

    assign in_ready     = (state_reg == S_RUN) && !out_valid_reg;
    assign cmd.accept   = in_valid && in_ready;
    assign cmd.div_step = state_reg == S_DIV;
    assign div_last     = cnt_reg == whp_pkg::CNT_W'(whp_pkg::DIV_STEPS - 1);
    assign out_valid    = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_RUN:
            begin
                if (cmd.accept && stat.emit)
                begin
                    if (stat.emit_ok)
                    begin
                        state_next = S_DIV;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next     = S_RUN;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && stat.emit && !stat.emit_ok |=> out_valid_reg)
        else $error("error result not presented");

    a_ok_divides: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && stat.emit && stat.emit_ok |=> state_reg == S_DIV && !out_valid_reg)
        else $error("ok result did not start division");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && div_last |=> state_reg == S_RUN && out_valid_reg)
        else $error("division end did not present result");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV || out_valid_reg) |-> !cmd.accept)
        else $error("item accepted while busy");

endmodule

`default_nettype wire

### design/wav_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wav_header_parser
// canonical 44-byte riff/wave pcm header parser
// ----------------------------------------------------------------------------
// Header bytes are taken one item per cycle. A failed check or a premature
// last byte presents its result in the cycle after that byte. After byte 43
// the duration comes from a restoring divider that yields one quotient bit a
// cycle; the ok result comes with the last quotient bit. No byte is taken
// while the divider runs or while a result waits at the output; once it is
// taken, bytes up to the file's last byte are consumed at one per cycle.
module wav_header_parser (
    input wire            clk,
    input wire            rst_n,
    whp_byte_if.sink      stream,
    whp_result_if.source  result
);

    whp_pkg::cmd_t  cmd;
    whp_pkg::stat_t stat;

    whp_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stream.valid),
        .in_ready  (stream.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    whp_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .data_byte        (stream.data_byte),
        .last_byte        (stream.last_byte),
        .stat             (stat),
        .status           (result.status),
        .chunk_size       (result.chunk_size),
        .audio_format     (result.audio_format),
        .num_channels     (result.num_channels),
        .sample_rate      (result.sample_rate),
        .byte_rate        (result.byte_rate),
        .bits_per_sample  (result.bits_per_sample),
        .data_size        (result.data_size),
        .duration_seconds (result.duration_seconds)
    );

endmodule

`default_nettype wire
